[sv/optimistic_tx_conflict_check_defines.svh]
// ----------------------------------------------------------------------------
// optimistic_tx_conflict_check_defines
// assertion macros shared by the conflict checker rtl
// ----------------------------------------------------------------------------
`ifndef OPTIMISTIC_TX_CONFLICT_CHECK_DEFINES_SVH
`define OPTIMISTIC_TX_CONFLICT_CHECK_DEFINES_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define OTCC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define OTCC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

[sv/otcc_pkg.sv]
// ----------------------------------------------------------------------------
// otcc_pkg
// transaction and result types of the optimistic conflict checker
// ----------------------------------------------------------------------------
`default_nettype none

package otcc_pkg;

    typedef enum logic [1:0] {
        MODE_BEGIN  = 2'd0,
        MODE_READ   = 2'd1,
        MODE_WRITE  = 2'd2,
        MODE_COMMIT = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        OUT_DONE      = 3'd0,
        OUT_NOT_LIVE  = 3'd1,
        OUT_COMMITTED = 3'd2,
        OUT_ABORTED   = 3'd3,
        OUT_NO_FREE   = 3'd4
    } t_outcome;

    typedef struct packed {
        t_mode      mode;
        logic [3:0] tx_slot;
        logic [5:0] item;
    } t_cmd;

    typedef struct packed {
        t_outcome   outcome;
        logic [3:0] given_slot;
    } t_res;

endpackage

`default_nettype wire

[sv/optimistic_tx_conflict_check.sv]
// ----------------------------------------------------------------------------
// optimistic_tx_conflict_check
// forward optimistic concurrency control tracker: slot allocation, read and
// write set bitmaps, and a commit check against the other live transactions
// a slot that is not live is answered in the cycle after accept; read and write
//   pass through ST_RMW, begin walks ST_BEGIN from slot 0 up to the lowest free
//   slot (or the last slot with none free), and commit runs ST_CMT_SCAN, ST_CMT_LAST
// busy is low while the result strobe is shown, so the next transaction can be taken
//   at the edge that ends the result cycle
// commit time is set by the conflict scan, one read-set memory row per cycle
// reset (synchronous, active low) frees every slot; results cannot be stalled
// ----------------------------------------------------------------------------
`default_nettype none

`include "optimistic_tx_conflict_check_defines.svh"

module optimistic_tx_conflict_check #(
    parameter int TX_SLOTS  = 16,
    parameter int NUM_ITEMS = 64
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire otcc_pkg::t_cmd i_cmd,
    output logic               o_strobe,
    output otcc_pkg::t_res     o_res
);

    localparam int SLOT_W = $clog2(TX_SLOTS);
    localparam int ITEM_W = (NUM_ITEMS > 1) ? $clog2(NUM_ITEMS) : 1;
    // slot number as wide as both the port field and the slot index
    localparam int EXT_W  = (SLOT_W > 4) ? SLOT_W : 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RMW,
        ST_BEGIN,
        ST_CMT_SCAN,
        ST_CMT_LAST
    } t_state;

    t_state                 r_state;
    logic [TX_SLOTS-1:0]    r_live;
    otcc_pkg::t_mode        r_mode;
    logic [3:0]             r_tx_slot;
    logic [SLOT_W-1:0]      r_slot;
    logic [5:0]             r_item;
    logic                   r_item_ok;
    logic [SLOT_W-1:0]      r_idx;
    logic [SLOT_W-1:0]      r_cmp_idx;
    logic                   r_cmp_vld;
    logic                   r_conflict;

    // read and write set memories, one row per slot, registered read data
    logic [NUM_ITEMS-1:0]   r_rd_bmap [TX_SLOTS];
    logic [NUM_ITEMS-1:0]   r_wr_bmap [TX_SLOTS];
    logic [NUM_ITEMS-1:0]   r_rd_q;
    logic [NUM_ITEMS-1:0]   r_wr_q;

    logic [EXT_W-1:0]       slot_ext;
    logic                   slot_ok;
    logic                   accept;
    logic [NUM_ITEMS-1:0]   item_bit;
    logic                   hit;
    logic                   last_idx;

    logic [SLOT_W-1:0]      rd_raddr;
    logic [SLOT_W-1:0]      wr_raddr;
    logic                   rd_we;
    logic                   wr_we;
    logic [SLOT_W-1:0]      rd_waddr;
    logic [SLOT_W-1:0]      wr_waddr;
    logic [NUM_ITEMS-1:0]   rd_wdata;
    logic [NUM_ITEMS-1:0]   wr_wdata;

    // result classes seen by the checks at the bottom
    logic                   cmt_res;
    logic                   no_free_res;
    logic                   done_res;
    logic                   begin_take;

    assign busy     = (r_state != ST_IDLE);
    assign accept   = start && !busy;
    assign slot_ext = EXT_W'(i_cmd.tx_slot);
    // slots past the end count as not live
    assign slot_ok  = ({1'b0, slot_ext} < (EXT_W + 1)'(TX_SLOTS))
                      && r_live[slot_ext[SLOT_W-1:0]];
    assign item_bit = NUM_ITEMS'(1) << r_item[ITEM_W-1:0];
    assign last_idx = (r_idx == SLOT_W'(TX_SLOTS - 1));

    // shared compare unit: one other slot's read set against our write set
    assign hit = r_cmp_vld && (r_cmp_idx != r_slot) && r_live[r_cmp_idx]
                 && (|(r_rd_q & r_wr_q));

    // memory port steering
    always_comb begin
        rd_raddr = r_idx;
        wr_raddr = r_slot;
        rd_we    = 1'b0;
        wr_we    = 1'b0;
        rd_waddr = r_slot;
        wr_waddr = r_slot;
        rd_wdata = r_rd_q | item_bit;
        wr_wdata = r_wr_q | item_bit;
        unique case (r_state)
            ST_IDLE: begin
                // prefetch the addressed slot's rows for read, write or commit
                rd_raddr = slot_ext[SLOT_W-1:0];
                wr_raddr = slot_ext[SLOT_W-1:0];
            end
            ST_RMW: begin
                rd_we = r_item_ok && (r_mode == otcc_pkg::MODE_READ);
                wr_we = r_item_ok && (r_mode == otcc_pkg::MODE_WRITE);
            end
            ST_BEGIN: begin
                // a newly allocated slot starts with empty sets
                rd_we    = !r_live[r_idx];
                wr_we    = !r_live[r_idx];
                rd_waddr = r_idx;
                wr_waddr = r_idx;
                rd_wdata = '0;
                wr_wdata = '0;
            end
            ST_CMT_SCAN, ST_CMT_LAST: begin
                rd_raddr = r_idx;
            end
            default: begin
                rd_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rd_q <= r_rd_bmap[rd_raddr];
        if (rd_we) begin
            r_rd_bmap[rd_waddr] <= rd_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_q <= r_wr_bmap[wr_raddr];
        if (wr_we) begin
            r_wr_bmap[wr_waddr] <= wr_wdata;
        end
    end

    // sequencer, slot live bits and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_live    <= '0;
            o_strobe  <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_mode     <= i_cmd.mode;
                        r_tx_slot  <= i_cmd.tx_slot;
                        r_slot     <= slot_ext[SLOT_W-1:0];
                        r_item     <= i_cmd.item;
                        r_item_ok  <= ({1'b0, i_cmd.item} < 7'(NUM_ITEMS));
                        r_idx      <= '0;
                        r_cmp_vld  <= 1'b0;
                        r_conflict <= 1'b0;
                        priority if (i_cmd.mode == otcc_pkg::MODE_BEGIN) begin
                            r_state <= ST_BEGIN;
                        end else if (!slot_ok) begin
                            // rejected at once, no state change
                            o_strobe         <= 1'b1;
                            o_res.outcome    <= otcc_pkg::OUT_NOT_LIVE;
                            o_res.given_slot <= i_cmd.tx_slot;
                        end else if (i_cmd.mode == otcc_pkg::MODE_COMMIT) begin
                            r_state <= ST_CMT_SCAN;
                        end else begin
                            r_state <= ST_RMW;
                        end
                    end
                end
                ST_RMW: begin
                    // memory row arrived, write-back set by the steering logic
                    o_strobe         <= 1'b1;
                    o_res.outcome    <= otcc_pkg::OUT_DONE;
                    o_res.given_slot <= r_tx_slot;
                    r_state          <= ST_IDLE;
                end
                ST_BEGIN: begin
                    // walk slots from the bottom until a free one shows up or the last one is full
                    priority if (!r_live[r_idx]) begin
                        r_live[r_idx]    <= 1'b1;
                        o_strobe         <= 1'b1;
                        o_res.outcome    <= otcc_pkg::OUT_DONE;
                        o_res.given_slot <= 4'(r_idx);
                        r_state          <= ST_IDLE;
                    end else if (last_idx) begin
                        o_strobe         <= 1'b1;
                        o_res.outcome    <= otcc_pkg::OUT_NO_FREE;
                        o_res.given_slot <= '0;
                        r_state          <= ST_IDLE;
                    end else begin
                        r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                ST_CMT_SCAN: begin
                    // issue one read-set row per cycle, compare it in the cycle after
                    r_cmp_vld  <= 1'b1;
                    r_cmp_idx  <= r_idx;
                    r_conflict <= r_conflict | hit;
                    if (last_idx) begin
                        r_state <= ST_CMT_LAST;
                    end else begin
                        r_idx <= r_idx + SLOT_W'(1);
                    end
                end
                ST_CMT_LAST: begin
                    // last row compare, then free the slot
                    r_cmp_vld        <= 1'b0;
                    r_live[r_slot]   <= 1'b0;
                    o_strobe         <= 1'b1;
                    o_res.outcome    <= (r_conflict | hit) ? otcc_pkg::OUT_ABORTED
                                                           : otcc_pkg::OUT_COMMITTED;
                    o_res.given_slot <= r_tx_slot;
                    r_state          <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign cmt_res     = (o_res.outcome == otcc_pkg::OUT_COMMITTED)
                         || (o_res.outcome == otcc_pkg::OUT_ABORTED);
    assign no_free_res = (o_res.outcome == otcc_pkg::OUT_NO_FREE);
    assign done_res    = (o_res.outcome == otcc_pkg::OUT_DONE);
    assign begin_take  = (r_state == ST_BEGIN) && !r_live[r_idx];

    // a result is only ever shown once the sequencer is back at rest
    `OTCC_ASSERT_NOW(a_strobe_idle, o_strobe, !busy, "result strobe while busy")

    // the committing slot stays live for the whole scan
    `OTCC_ASSERT_NOW(a_scan_live, r_state == ST_CMT_SCAN, r_live[r_slot], "commit slot not live")

    // a finished commit or abort leaves its slot free
    `OTCC_ASSERT_NOW(a_commit_frees, o_strobe && cmt_res, !r_live[r_slot], "slot still live")

    // no free slot is reported only when every slot is taken
    `OTCC_ASSERT_NOW(a_no_free_full, o_strobe && no_free_res, &r_live, "free slot left")

    // a begin that finds a free slot reports it right away
    `OTCC_ASSERT_NEXT(a_begin_live, begin_take, o_strobe && done_res, "begin took no slot")

endmodule

`default_nettype wire

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the optimistic conflict checker: directed and
// random operations are predicted and compared field by field
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

    // geometry of the block as instantiated
    localparam int SLOTS = 16;
    localparam int ITEMS = 64;

    // number of random phases and of random picks in each phase (a fill burst queues several)
    localparam int PHASES          = 4;
    localparam int ITEMS_PER_PHASE = 370;

    // one queued operation for the driver
    typedef struct {
        otcc_pkg::t_cmd cmd;
        int unsigned    idle_pct;  // chance of an idle cycle before it is offered
        bit             hold_off;  // wait until every pending result has come back
    } t_stim;

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           start   = 1'b0;
    logic           busy;
    otcc_pkg::t_cmd i_cmd   = '0;
    logic           o_strobe;
    otcc_pkg::t_res o_res;

    optimistic_tx_conflict_check #(
        .TX_SLOTS  (SLOTS),
        .NUM_ITEMS (ITEMS)
    ) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .o_strobe (o_strobe),
        .o_res    (o_res)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // predicted state of the tracker
    // ------------------------------------------------------------------------
    bit          live_slot [SLOTS];
    logic [63:0] read_set  [SLOTS];
    logic [63:0] write_set [SLOTS];

    t_stim          pending_ops [$];   // operations waiting for the driver
    otcc_pkg::t_res expected_q  [$];   // predicted results, oldest first
    int unsigned    mismatch_count = 0;
    int unsigned    result_count   = 0;
    logic           accept_seen    = 1'b0;
    otcc_pkg::t_res oldest;
    t_stim          next_op;

    // generator-side view of which slots are live, so random transactions
    // can mostly target slots that really exist
    bit          gen_live [SLOTS];

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch: %s got %0d expected %0d at result %0d",
                 what, got, want, result_count);
        mismatch_count++;
    endtask

    // applies one accepted operation to the predicted state and returns
    // the result the block must produce for it
    function automatic otcc_pkg::t_res apply_cmd(input otcc_pkg::t_cmd c);
        otcc_pkg::t_res r;
        int   s;
        bit   clash;
        bit   found;
        s            = c.tx_slot;
        r.outcome    = otcc_pkg::OUT_DONE;
        r.given_slot = c.tx_slot;
        clash        = 1'b0;
        found        = 1'b0;
        if (c.mode == otcc_pkg::MODE_BEGIN) begin
            // lowest free slot wins; a full table leaves everything alone
            r.outcome    = otcc_pkg::OUT_NO_FREE;
            r.given_slot = '0;
            for (int j = 0; j < SLOTS; j++) begin
                if (!found && !live_slot[j]) begin
                    found        = 1'b1;
                    live_slot[j] = 1'b1;
                    read_set[j]  = '0;
                    write_set[j] = '0;
                    r.outcome    = otcc_pkg::OUT_DONE;
                    r.given_slot = j[3:0];
                end
            end
        end else if (s >= SLOTS || !live_slot[s]) begin
            r.outcome = otcc_pkg::OUT_NOT_LIVE;
        end else if (c.mode == otcc_pkg::MODE_READ) begin
            if (c.item < ITEMS) read_set[s][c.item] = 1'b1;
        end else if (c.mode == otcc_pkg::MODE_WRITE) begin
            if (c.item < ITEMS) write_set[s][c.item] = 1'b1;
        end else begin
            // write set against the read sets of the other live slots only
            for (int j = 0; j < SLOTS; j++) begin
                if (j != s && live_slot[j] && (write_set[s] & read_set[j]) != '0)
                    clash = 1'b1;
            end
            r.outcome    = clash ? otcc_pkg::OUT_ABORTED : otcc_pkg::OUT_COMMITTED;
            live_slot[s] = 1'b0;
            read_set[s]  = '0;
            write_set[s] = '0;
        end
        return r;
    endfunction

    // queues one operation and keeps the generator's liveness view in step
    task automatic add_cmd(input otcc_pkg::t_mode m, input int slot, input int itm,
                           input int unsigned pct, input bit hold);
        t_stim st;
        bit    found;
        st.cmd.mode    = m;
        st.cmd.tx_slot = slot[3:0];
        st.cmd.item    = itm[5:0];
        st.idle_pct    = pct;
        st.hold_off    = hold;
        found          = 1'b0;
        if (m == otcc_pkg::MODE_BEGIN) begin
            for (int j = 0; j < SLOTS; j++) begin
                if (!found && !gen_live[j]) begin
                    found       = 1'b1;
                    gen_live[j] = 1'b1;
                end
            end
        end else if (m == otcc_pkg::MODE_COMMIT) begin
            gen_live[slot[3:0]] = 1'b0;
        end
        pending_ops.insert(pending_ops.size(), st);
    endtask

    function automatic int count_live();
        int n;
        n = 0;
        for (int j = 0; j < SLOTS; j++) n += gen_live[j];
        return n;
    endfunction

    // picks a live slot at random, or a random slot when none is live
    function automatic int pick_live();
        int idx [$];
        for (int j = 0; j < SLOTS; j++) if (gen_live[j]) idx.insert(idx.size(), j);
        if (idx.size() == 0) return $urandom_range(SLOTS - 1);
        return idx[$urandom_range(idx.size() - 1)];
    endfunction

    // mostly a small hot set of items so that conflicts are common
    function automatic int pick_item();
        if ($urandom_range(99) < 70) return $urandom_range(7);
        return $urandom_range(ITEMS - 1);
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers operations on the falling edge, holds each one until
    // the block takes it
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || accept_seen) begin
            if (pending_ops.size() == 0) begin
                start <= 1'b0;
            end else if ($urandom_range(99) < pending_ops[0].idle_pct) begin
                start <= 1'b0;
            end else if (pending_ops[0].hold_off && expected_q.size() != 0) begin
                // pause until the block has answered everything in flight
                start <= 1'b0;
            end else begin
                next_op = pending_ops.pop_front();
                i_cmd <= next_op.cmd;
                start <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: checks results and records accepted transactions on the
    // rising edge; the check comes first since a result and a new accept
    // can share an edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            accept_seen <= 1'b0;
        end else begin
            if (o_strobe) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result, outcome", o_res.outcome, 0);
                end else begin
                    oldest = expected_q.pop_front();
                    if (o_res.outcome !== oldest.outcome)
                        report_mismatch("outcome", o_res.outcome, oldest.outcome);
                    if (o_res.given_slot !== oldest.given_slot)
                        report_mismatch("given_slot", o_res.given_slot,
                                        oldest.given_slot);
                end
                result_count++;
            end
            if (start && !busy) expected_q.insert(expected_q.size(), apply_cmd(i_cmd));
            accept_seen <= start && !busy;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    int unsigned phase_idle [PHASES] = '{0, 65, 0, 24};
    int          r;
    int          live_n;
    int          drain_wait;

    initial begin
        for (int j = 0; j < SLOTS; j++) begin
            live_slot[j] = 1'b0;
            read_set[j]  = '0;
            write_set[j] = '0;
            gen_live[j]  = 1'b0;
        end

        // directed part: dead slots, fill to the last slot, table full,
        // extreme items, conflict abort, empty write set, own read set
        add_cmd(otcc_pkg::MODE_READ,   5,  0,  0, 1'b0);
        add_cmd(otcc_pkg::MODE_WRITE,  15, 63, 0, 1'b0);
        add_cmd(otcc_pkg::MODE_COMMIT, 0,  0,  0, 1'b0);
        for (int j = 0; j < SLOTS; j++)
            add_cmd(otcc_pkg::MODE_BEGIN, 15 - j, 63 - j, 0, 1'b0);
        add_cmd(otcc_pkg::MODE_BEGIN,  9,  42, 0, 1'b0);
        add_cmd(otcc_pkg::MODE_READ,   0,  63, 0, 1'b0);
        add_cmd(otcc_pkg::MODE_READ,   1,  0,  0, 1'b0);
        add_cmd(otcc_pkg::MODE_WRITE,  15, 63, 0, 1'b0);
        add_cmd(otcc_pkg::MODE_COMMIT, 15, 63, 0, 1'b0);
        add_cmd(otcc_pkg::MODE_COMMIT, 2,  21, 0, 1'b0);
        add_cmd(otcc_pkg::MODE_WRITE,  1,  0,  0, 1'b0);
        add_cmd(otcc_pkg::MODE_COMMIT, 1,  0,  0, 1'b0);

        // random part: phases of sender idling, each opened by a drain pause unless its first pick is a fill burst
        for (int p = 0; p < PHASES; p++) begin
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                r      = $urandom_range(99);
                live_n = count_live();
                if (r < 12) begin
                    // noise: anything the fields allow
                    add_cmd(otcc_pkg::t_mode'($urandom_range(3)),
                            $urandom_range(SLOTS - 1),
                            $urandom_range(ITEMS - 1), phase_idle[p], k == 0);
                end else if (r == 12) begin
                    // fill burst: run the table full and one past it
                    for (int j = live_n; j <= SLOTS; j++)
                        add_cmd(otcc_pkg::MODE_BEGIN, $urandom_range(SLOTS - 1),
                                $urandom_range(ITEMS - 1), phase_idle[p], 1'b0);
                end else if (live_n == 0 || (live_n < 3 && r < 50) ||
                             (live_n < 14 && r < 26)) begin
                    add_cmd(otcc_pkg::MODE_BEGIN, $urandom_range(SLOTS - 1),
                            $urandom_range(ITEMS - 1), phase_idle[p], k == 0);
                end else begin
                    r = $urandom_range(99);
                    if (r < 45)
                        add_cmd(otcc_pkg::MODE_READ, pick_live(), pick_item(),
                                phase_idle[p], k == 0);
                    else if (r < 75)
                        add_cmd(otcc_pkg::MODE_WRITE, pick_live(), pick_item(),
                                phase_idle[p], k == 0);
                    else
                        add_cmd(otcc_pkg::MODE_COMMIT, pick_live(),
                                $urandom_range(ITEMS - 1), phase_idle[p], k == 0);
                end
            end
        end

        // synchronous reset, released on a falling edge
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // every operation offered and taken
        do @(posedge i_clk); while (pending_ops.size() != 0 || start);

        // let the last commit scan finish, bounded
        drain_wait = 0;
        while (expected_q.size() != 0 && drain_wait < 2000) begin
            @(posedge i_clk);
            drain_wait++;
        end
        repeat (2 * SLOTS + 4) @(posedge i_clk);
        if (expected_q.size() != 0)
            report_mismatch("results never returned, count", expected_q.size(), 0);

        if (mismatch_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #4000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
+incdir+sv
sv/otcc_pkg.sv
sv/optimistic_tx_conflict_check.sv
dv/testbench.sv
